/* hdl/bsy_pkg.sv */
// ----------------------------------------------------------------------------
// bsy_pkg
// Shared types, register codes and pixel arithmetic for the BGR scaler.
// ----------------------------------------------------------------------------
package bsy_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH  = 320;
  localparam int DEF_MAX_SOURCE_HEIGHT = 240;
  localparam int DEF_MAX_TARGET_SIZE   = 2048;

  localparam int LOAD_W    = 17;
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 13;
  localparam int APB_AW    = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FLIP_H        = 3'd4;
  localparam logic [2:0] REG_FLIP_V        = 3'd5;

  localparam logic [7:0] BLACK_LEVEL = 8'h10;

  typedef struct packed {
    logic       opcode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
    logic       row_end;
    logic       frame_end;
    logic       geometry_ok;
  } out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  function automatic logic [7:0] clip8(int val, int lo, int hi);
    int c;
    c = (val < lo) ? lo : ((val > hi) ? hi : val);
    return 8'(c);
  endfunction

  function automatic yuv_t convert(logic [23:0] bgr);
    int b;
    int g;
    int r;
    yuv_t o;
    b = int'(bgr[7:0]);
    g = int'(bgr[15:8]);
    r = int'(bgr[23:16]);
    o.y = clip8(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16, 16, 235);
    o.u = clip8((-38 * r - 74 * g + 112 * b + 128 + 32768) >>> 8, 16, 240);
    o.v = clip8((112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8, 16, 240);
    return o;
  endfunction

  function automatic logic [8:0] pick(logic [DIV_NUM_W-1:0] q, logic [8:0] size,
                                      logic mirror);
    logic [8:0] s;
    s = (q >= DIV_NUM_W'(size)) ? size - 9'd1 : q[8:0];
    if (mirror) begin
      s = size - 9'd1 - s;
    end
    return s;
  endfunction

endpackage

/* hdl/bsy_ram.sv */
// ----------------------------------------------------------------------------
// bsy_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bsy_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 76800,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bsy_div.sv */
// ----------------------------------------------------------------------------
// bsy_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsy_div (
  input  logic              clk,
  input  logic              rst,
  input  bsy_pkg::div_req_t req,
  output bsy_pkg::div_rsp_t rsp
);

  localparam int NW = bsy_pkg::DIV_NUM_W;
  localparam int DW = bsy_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem, num_sh[NW-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num_sh <= req.num;
        den    <= req.den;
        rem    <= '0;
        cnt    <= CW'(NW);
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= fits ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
        num_sh <= {num_sh[NW-2:0], fits};
        cnt    <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num_sh;

endmodule

/* hdl/bgra_scale_to_yuy2.sv */
// ----------------------------------------------------------------------------
// bgra_scale_to_yuy2
// Letterboxing nearest-neighbour scaler from a BGR frame store to YUY2 bytes.
// ----------------------------------------------------------------------------
// A load word is handled in S_IDLE. For an emit word, a
// letterbox pixel needs one or two fit divisions, an image pixel four or five,
// each on the one shared bit-serial divider, plus two frame-store reads and
// conversion. A finished pixel waits in the output register while the next
// word is taken. The frame store needs no clearing pass.
module bgra_scale_to_yuy2 #(
  parameter int MAX_SOURCE_WIDTH  = bsy_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = bsy_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_TARGET_SIZE   = bsy_pkg::DEF_MAX_TARGET_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsy_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bsy_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsy_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_TARGET_SIZE);
  localparam int TW    = CW + 1;
  localparam int LW    = bsy_pkg::LOAD_W;
  localparam int NW    = bsy_pkg::DIV_NUM_W;
  localparam int DW    = bsy_pkg::DIV_DEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVH, S_DIVW, S_FIT, S_DIVY, S_DIVA, S_DIVB, S_RDB, S_CONV, S_PUT
  } state_t;

  state_t state;

  logic [8:0]  src_w;
  logic [7:0]  src_h;
  logic [11:0] tgt_w;
  logic [11:0] tgt_h;
  logic        flip_h;
  logic        flip_v;

  logic [LW-1:0] load_addr;
  logic [CW-1:0] col;
  logic [CW-1:0] row;

  logic [CW-1:0] c_q;
  logic [CW-1:0] r_q;
  logic          re_q;
  logic          fe_q;
  logic [TW-1:0] w;
  logic [TW-1:0] h;
  logic [TW-1:0] xa;
  logic [TW-1:0] xb;
  logic          odd;
  logic [7:0]    sy;
  logic [23:0]   pa;
  logic          za;
  logic          zb;
  bsy_pkg::yuv_t ca;
  bsy_pkg::out_t res;

  bsy_pkg::div_req_t div_req;
  bsy_pkg::div_rsp_t div_rsp;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [23:0]   ram_rdata;

  logic [TW-1:0] tws;
  logic [TW-1:0] ths;
  logic          geo_nz;
  logic          acc;
  logic          cfg_wr;
  logic [LW-1:0] frame_px;
  logic          row_end;
  logic          frame_end;

  logic [TW-1:0] x0;
  logic [TW-1:0] y0;
  logic [TW-1:0] xr;
  logic [TW-1:0] yr;
  logic          in_image;
  logic [TW-1:0] xa_c;
  logic [TW-1:0] xb_c;
  logic [8:0]    sx_c;
  logic [LW-1:0] faddr;
  logic          fzero;
  bsy_pkg::yuv_t cb;
  logic [8:0]    usum;
  logic [8:0]    vsum;

  assign tws = ({1'b0, tgt_w} > 13'(MAX_TARGET_SIZE)) ? TW'(MAX_TARGET_SIZE) : TW'(tgt_w);
  assign ths = ({1'b0, tgt_h} > 13'(MAX_TARGET_SIZE)) ? TW'(MAX_TARGET_SIZE) : TW'(tgt_h);
  assign geo_nz = (src_w != '0) && (src_h != '0) && (tws != '0) && (ths != '0);

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  assign frame_px  = LW'(src_w * src_h);
  assign row_end   = ({1'b0, col} + TW'(1)) >= tws;
  assign frame_end = row_end && (({1'b0, row} + TW'(1)) >= ths);

  assign x0       = (tws - w) >> 1;
  assign y0       = (ths - h) >> 1;
  assign xr       = {1'b0, c_q} - x0;
  assign yr       = {1'b0, r_q} - y0;
  assign in_image = ({1'b0, r_q} >= y0) && (yr < h) && ({1'b0, c_q} >= x0) &&
                    ((xr < w) || ((xr == w) && w[0] && ({1'b0, c_q} < tws)));
  assign xa_c     = {xr[TW-1:1], 1'b0};
  assign xb_c     = ((xa_c + TW'(1)) < w) ? xa_c + TW'(1) : xa_c;

  assign sx_c  = bsy_pkg::pick(div_rsp.quot, src_w, flip_h);
  assign faddr = LW'(sy * src_w) + LW'(sx_c);
  assign fzero = 32'(faddr) >= DEPTH;

  assign cb   = bsy_pkg::convert(zb ? 24'd0 : ram_rdata);
  assign usum = {1'b0, ca.u} + {1'b0, cb.u};
  assign vsum = {1'b0, ca.v} + {1'b0, cb.v};

  assign ram_we = acc && (in_data.opcode == bsy_pkg::OP_LOAD) && (32'(load_addr) < DEPTH);

  bsy_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(load_addr)),
    .wdata ({in_data.red, in_data.green, in_data.blue}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsy_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    unique case (paddr[4:2])
      bsy_pkg::REG_SOURCE_WIDTH:  prdata = 32'(src_w);
      bsy_pkg::REG_SOURCE_HEIGHT: prdata = 32'(src_h);
      bsy_pkg::REG_TARGET_WIDTH:  prdata = 32'(tgt_w);
      bsy_pkg::REG_TARGET_HEIGHT: prdata = 32'(tgt_h);
      bsy_pkg::REG_FLIP_H:        prdata = 32'(flip_h);
      bsy_pkg::REG_FLIP_V:        prdata = 32'(flip_v);
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w  <= 9'd320;
      src_h  <= 8'd240;
      tgt_w  <= 12'd640;
      tgt_h  <= 12'd480;
      flip_h <= 1'b0;
      flip_v <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        bsy_pkg::REG_SOURCE_WIDTH:  src_w  <= pwdata[8:0];
        bsy_pkg::REG_SOURCE_HEIGHT: src_h  <= pwdata[7:0];
        bsy_pkg::REG_TARGET_WIDTH:  tgt_w  <= pwdata[11:0];
        bsy_pkg::REG_TARGET_HEIGHT: tgt_h  <= pwdata[11:0];
        bsy_pkg::REG_FLIP_H:        flip_h <= pwdata[0];
        bsy_pkg::REG_FLIP_V:        flip_v <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_addr     <= '0;
      col           <= '0;
      row           <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && (in_data.opcode == bsy_pkg::OP_LOAD)) begin
            load_addr <= ((load_addr + LW'(1)) >= frame_px) ? '0 : load_addr + LW'(1);
          end else if (acc) begin
            c_q  <= col;
            r_q  <= row;
            re_q <= row_end;
            fe_q <= frame_end;
            if (row_end) begin
              col <= '0;
              row <= frame_end ? '0 : row + CW'(1);
            end else begin
              col <= col + CW'(1);
            end
            if (geo_nz) begin
              div_req.start <= 1'b1;
              div_req.num   <= NW'(tws * src_h);
              div_req.den   <= DW'(src_w);
              state         <= S_DIVH;
            end else begin
              res   <= '{bsy_pkg::BLACK_LEVEL, bsy_pkg::BLACK_LEVEL, row_end, frame_end, 1'b0};
              state <= S_PUT;
            end
          end
        end
        S_DIVH: begin
          if (div_rsp.done) begin
            if (div_rsp.quot > NW'(ths)) begin
              h             <= ths;
              div_req.start <= 1'b1;
              div_req.num   <= NW'(ths * src_w);
              div_req.den   <= DW'(src_h);
              state         <= S_DIVW;
            end else begin
              h     <= TW'(div_rsp.quot);
              w     <= tws;
              state <= S_FIT;
            end
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            w     <= TW'(div_rsp.quot);
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if ((w == '0) || (h == '0)) begin
            res   <= '{bsy_pkg::BLACK_LEVEL, bsy_pkg::BLACK_LEVEL, re_q, fe_q, 1'b0};
            state <= S_PUT;
          end else if (!in_image) begin
            res   <= '{bsy_pkg::BLACK_LEVEL, bsy_pkg::BLACK_LEVEL, re_q, fe_q, 1'b1};
            state <= S_PUT;
          end else begin
            xa            <= xa_c;
            xb            <= xb_c;
            odd           <= xr[0];
            div_req.start <= 1'b1;
            div_req.num   <= NW'(yr * src_h);
            div_req.den   <= DW'(h);
            state         <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            sy            <= 8'(bsy_pkg::pick(div_rsp.quot, {1'b0, src_h}, flip_v));
            div_req.start <= 1'b1;
            div_req.num   <= NW'(xa * src_w);
            div_req.den   <= DW'(w);
            state         <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_rsp.done) begin
            ram_raddr     <= AW'(faddr);
            za            <= fzero;
            div_req.start <= 1'b1;
            div_req.num   <= NW'(xb * src_w);
            div_req.den   <= DW'(w);
            state         <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_rsp.done) begin
            pa        <= ram_rdata;
            ram_raddr <= AW'(faddr);
            zb        <= fzero;
            state     <= S_RDB;
          end
        end
        S_RDB: begin
          ca    <= bsy_pkg::convert(za ? 24'd0 : pa);
          state <= S_CONV;
        end
        S_CONV: begin
          res.luma        <= odd ? cb.y : ca.y;
          res.chroma      <= odd ? vsum[8:1] : usum[8:1];
          res.row_end     <= re_q;
          res.frame_end   <= fe_q;
          res.geometry_ok <= 1'b1;
          state           <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/bsy_chk.sv */
// ----------------------------------------------------------------------------
// bsy_chk
// Port-level checks for the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module bsy_chk (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input bsy_pkg::out_t out_data,
  input logic          pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame end without row end");

  a_bad_geo: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.geometry_ok |->
      (out_data.luma == bsy_pkg::BLACK_LEVEL) && (out_data.chroma == bsy_pkg::BLACK_LEVEL))
    else $error("bad geometry word carries pixel data");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind bgra_scale_to_yuy2 bsy_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

/* bench/tb_bgra_scale_to_yuy2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bgra_scale_to_yuy2
// Self-checking bench for the letterboxing BGR to YUY2 scaler. A queue of
// load and emit words feeds a clocked driver; a clocked monitor compares each
// output word with a pixel predicted from a private copy of the frame store,
// counters and registers. Phases sweep the registers over small, odd,
// zero, saturating and extreme geometries with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_bgra_scale_to_yuy2;

  localparam int STORE_DEPTH = bsy_pkg::DEF_MAX_SOURCE_WIDTH * bsy_pkg::DEF_MAX_SOURCE_HEIGHT;
  localparam int CYCLE_LIMIT = 4000000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  bsy_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bsy_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [bsy_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  bgra_scale_to_yuy2 u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [23:0] pix_store [0:STORE_DEPTH-1];
  int unsigned load_addr = 0, col = 0, row = 0;
  int unsigned src_w = 320, src_h = 240, dst_w = 640, dst_h = 480;
  int unsigned hflip = 0, vflip = 0;

  bsy_pkg::in_t  word_queue [$];
  bsy_pkg::out_t pixel_due [$];
  int   errors = 0;
  int   cycles = 0;
  bit   burst = 0;
  bit   long_hold_req = 0;
  int   in_gap = 0;
  int   out_stall = 0;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned sample_index(int unsigned pos, int unsigned scaled,
                                               int unsigned size, int unsigned mirror);
    longint unsigned s;
    s = (longint'(pos) * size) / scaled;
    if (s >= size) s = size - 1;
    if (mirror != 0) s = size - 1 - s;
    return int'(s);
  endfunction

  function automatic logic [23:0] store_read(int unsigned sx, int unsigned sy);
    int unsigned a;
    a = sy * src_w + sx;
    return a < STORE_DEPTH ? pix_store[a] : 24'd0;
  endfunction

  function automatic void to_yuv(logic [23:0] bgr, output int y, output int u,
                                 output int v);
    int b, g, r;
    b = bgr[7:0];
    g = bgr[15:8];
    r = bgr[23:16];
    y = clip(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16, 16, 235);
    u = clip((-38 * r - 74 * g + 112 * b + 128 + 32768) >>> 8, 16, 240);
    v = clip((112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8, 16, 240);
  endfunction

  function automatic void scaler_step(bsy_pkg::in_t w);
    int unsigned tw, th, fw, fh, x0, y0, x, xa, xb, sy;
    int ya, ua, va, yb, ub, vb;
    bsy_pkg::out_t o;
    tw = dst_w > bsy_pkg::DEF_MAX_TARGET_SIZE ? bsy_pkg::DEF_MAX_TARGET_SIZE : dst_w;
    th = dst_h > bsy_pkg::DEF_MAX_TARGET_SIZE ? bsy_pkg::DEF_MAX_TARGET_SIZE : dst_h;
    if (w.opcode == bsy_pkg::OP_LOAD) begin
      if (load_addr < STORE_DEPTH) pix_store[load_addr] = {w.red, w.green, w.blue};
      load_addr = (load_addr + 1 >= src_w * src_h) ? 0 : load_addr + 1;
      return;
    end
    o = '0;
    o.luma = bsy_pkg::BLACK_LEVEL;
    o.chroma = bsy_pkg::BLACK_LEVEL;
    if (src_w != 0 && src_h != 0 && tw != 0 && th != 0) begin
      fw = tw;
      fh = (tw * src_h) / src_w;
      if (fh > th) begin
        fh = th;
        fw = (th * src_w) / src_h;
      end
      if (fw != 0 && fh != 0) begin
        x0 = (tw - fw) / 2;
        y0 = (th - fh) / 2;
        o.geometry_ok = 1'b1;
        if (row >= y0 && row - y0 < fh && col >= x0) begin
          x = col - x0;
          if (x < fw || (x == fw && fw[0] && col < tw)) begin
            xa = x & ~32'd1;
            xb = (xa + 1 < fw) ? xa + 1 : xa;
            sy = sample_index(row - y0, fh, src_h, vflip);
            to_yuv(store_read(sample_index(xa, fw, src_w, hflip), sy), ya, ua, va);
            to_yuv(store_read(sample_index(xb, fw, src_w, hflip), sy), yb, ub, vb);
            if (!x[0]) begin
              o.luma = 8'(ya);
              o.chroma = 8'((ua + ub) / 2);
            end else begin
              o.luma = 8'(yb);
              o.chroma = 8'((va + vb) / 2);
            end
          end
        end
      end
    end
    o.row_end = (col + 1 >= tw);
    o.frame_end = o.row_end && (row + 1 >= th);
    if (o.row_end) begin
      col = 0;
      row = o.frame_end ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    pixel_due.push_back(o);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) scaler_step(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          in_data <= word_queue.pop_front();
          in_valid <= 1'b1;
          in_gap <= burst ? 0 : $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int nxt;
    bsy_pkg::out_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      nxt = out_stall;
      if (out_valid && out_ready) begin
        if (pixel_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        end else begin
          exp_w = pixel_due.pop_front();
          if (out_data.luma !== exp_w.luma || out_data.chroma !== exp_w.chroma ||
              out_data.row_end !== exp_w.row_end ||
              out_data.frame_end !== exp_w.frame_end ||
              out_data.geometry_ok !== exp_w.geometry_ok) begin
            errors++;
            $display("%0t: mismatch, expected %h, actual %h", $time, exp_w, out_data);
          end
        end
        nxt = burst ? 0 : $urandom_range(0, 12);
      end else if (nxt > 0) begin
        nxt--;
      end
      if (long_hold_req) begin
        nxt = 800;
        long_hold_req = 0;
      end
      out_stall <= nxt;
      out_ready <= (nxt == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bgra_scale_to_yuy2: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (word_queue.size() == 0 && !in_valid && pixel_due.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bsy_pkg::APB_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bsy_pkg::REG_SOURCE_WIDTH:  src_w = val & 32'h1FF;
      bsy_pkg::REG_SOURCE_HEIGHT: src_h = val & 32'hFF;
      bsy_pkg::REG_TARGET_WIDTH:  dst_w = val & 32'hFFF;
      bsy_pkg::REG_TARGET_HEIGHT: dst_h = val & 32'hFFF;
      bsy_pkg::REG_FLIP_H:        hflip = val & 1;
      bsy_pkg::REG_FLIP_V:        vflip = val & 1;
      default: ;
    endcase
  endtask

  function automatic bsy_pkg::in_t rand_word(logic op);
    bsy_pkg::in_t w;
    w.opcode = op;
    w.blue = 8'($urandom);
    w.green = 8'($urandom);
    w.red = 8'($urandom);
    return w;
  endfunction

  task automatic run_phase(int sw, int sh, int tw, int th, int fx, int fy,
                           int n_words, bit fill);
    wait_drained();
    reg_write(bsy_pkg::REG_SOURCE_WIDTH, sw);
    reg_write(bsy_pkg::REG_SOURCE_HEIGHT, sh);
    reg_write(bsy_pkg::REG_TARGET_WIDTH, tw);
    reg_write(bsy_pkg::REG_TARGET_HEIGHT, th);
    reg_write(bsy_pkg::REG_FLIP_H, fx);
    reg_write(bsy_pkg::REG_FLIP_V, fy);
    // cover the whole frame from wherever the load pointer stands
    if (fill) repeat (sw * sh + 1) word_queue.push_back(rand_word(bsy_pkg::OP_LOAD));
    repeat (n_words)
      word_queue.push_back(rand_word($urandom_range(0, 3) != 0 ? bsy_pkg::OP_EMIT
                                                                : bsy_pkg::OP_LOAD));
  endtask

  initial begin
    bsy_pkg::in_t w;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // odd fitted width with a letterbox column on the left, extreme colours
    wait_drained();
    reg_write(bsy_pkg::REG_SOURCE_WIDTH, 2);
    reg_write(bsy_pkg::REG_SOURCE_HEIGHT, 2);
    reg_write(bsy_pkg::REG_TARGET_WIDTH, 5);
    reg_write(bsy_pkg::REG_TARGET_HEIGHT, 3);
    reg_write(bsy_pkg::REG_FLIP_H, 0);
    reg_write(bsy_pkg::REG_FLIP_V, 0);
    w = '0;
    w.opcode = bsy_pkg::OP_LOAD;
    word_queue.push_back(w);
    w.blue = 8'hFF; w.green = 8'hFF; w.red = 8'hFF;
    word_queue.push_back(w);
    w.blue = 8'h00; w.green = 8'h00;
    word_queue.push_back(w);
    w.blue = 8'hFF; w.red = 8'h00;
    word_queue.push_back(w);
    w.opcode = bsy_pkg::OP_EMIT;
    repeat (15) word_queue.push_back(w);

    run_phase(2, 2, 5, 3, 1, 1, 15, 1'b0);
    run_phase(0, 2, 8, 8, 0, 0, 10, 1'b1);
    run_phase(3, 2, 0, 4, 0, 0, 6, 1'b1);
    run_phase(4, 3, 4095, 4095, 1, 0, 40, 1'b1);
    burst = 1;
    run_phase(511, 1, 2048, 1, 1, 1, 100, 1'b1);
    run_phase(1, 255, 1, 2048, 0, 1, 100, 1'b1);
    burst = 0;

    for (int p = 0; p < 12; p++) begin
      run_phase($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 20),
                $urandom_range(1, 20), $urandom_range(0, 1), $urandom_range(0, 1),
                24, 1'b1);
      burst = (p % 5 == 3);
      if (p == 4) long_hold_req = 1;
    end
    burst = 0;

    wait (word_queue.size() == 0 && !in_valid && pixel_due.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && pixel_due.size() == 0)
      $display("tb_bgra_scale_to_yuy2: clean");
    else
      $display("tb_bgra_scale_to_yuy2: errors");
    $finish;
  end

endmodule
